// ----- hw/rtl/rde_pkg.sv -----
// Shared types and codes for the integer decode/execute pipeline.
// No dependencies; used by rde_decode, rde_execute and the top level.
package rde_pkg;

    localparam int unsigned XLEN = 32;
    localparam int unsigned REG_ADDR_W = 5;

    // Major opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LW      = 6'h23;

    // R-format function codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_SLLV = 6'h04;
    localparam logic [5:0] FN_SRLV = 6'h06;
    localparam logic [5:0] FN_SRAV = 6'h07;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    localparam logic [4:0] RT_BLTZ = 5'd0;
    localparam logic [4:0] LINK_REG = 5'd31;
    localparam logic [XLEN-1:0] JUMP_REGION_MASK = 32'hF000_0000;

    // ALU operations
    localparam logic [3:0] ALU_ZERO = 4'd0;
    localparam logic [3:0] ALU_SLL  = 4'd1;
    localparam logic [3:0] ALU_SRL  = 4'd2;
    localparam logic [3:0] ALU_SRA  = 4'd3;
    localparam logic [3:0] ALU_ADD  = 4'd4;
    localparam logic [3:0] ALU_SUB  = 4'd5;
    localparam logic [3:0] ALU_AND  = 4'd6;
    localparam logic [3:0] ALU_OR   = 4'd7;
    localparam logic [3:0] ALU_XOR  = 4'd8;
    localparam logic [3:0] ALU_NOR  = 4'd9;
    localparam logic [3:0] ALU_SLT  = 4'd10;
    localparam logic [3:0] ALU_SLTU = 4'd11;
    localparam logic [3:0] ALU_PASS_B = 4'd12;

    // Branch / jump kinds
    localparam logic [2:0] BR_NONE = 3'd0;
    localparam logic [2:0] BR_EQ   = 3'd1;
    localparam logic [2:0] BR_NE   = 3'd2;
    localparam logic [2:0] BR_LTZ  = 3'd3;
    localparam logic [2:0] BR_LEZ  = 3'd4;
    localparam logic [2:0] BR_GTZ  = 3'd5;
    localparam logic [2:0] BR_JUMP = 3'd6;

    // Control word carried down the pipe
    typedef struct packed {
        logic [3:0]            alu_op;
        logic [2:0]            br_kind;
        logic [REG_ADDR_W-1:0] dest;
        logic                  reg_write;
        logic                  mem_load;
        logic                  illegal;
    } ctrl_t;

endpackage

// ----- hw/rtl/rde_decode.sv -----
// Stage 1: instruction decode, operand selection and branch/jump target add.
// Depends on rde_pkg.
module rde_decode (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic                               valid_in,
    input  logic [rde_pkg::XLEN-1:0]           instruction,
    input  logic [rde_pkg::XLEN-1:0]           rs_value,
    input  logic [rde_pkg::XLEN-1:0]           rt_value,
    input  logic [rde_pkg::XLEN-1:0]           pc_next,
    output logic                               valid,
    output rde_pkg::ctrl_t                     ctrl,
    output logic [rde_pkg::XLEN-1:0]           op_a,
    output logic [rde_pkg::XLEN-1:0]           op_b,
    output logic [4:0]                         shamt,
    output logic [rde_pkg::XLEN-1:0]           target
);

    logic                     valid_reg;
    rde_pkg::ctrl_t           ctrl_reg, ctrl_next;
    logic [rde_pkg::XLEN-1:0] op_a_reg, op_a_next;
    logic [rde_pkg::XLEN-1:0] op_b_reg, op_b_next;
    logic [4:0]               shamt_reg, shamt_next;
    logic [rde_pkg::XLEN-1:0] target_reg, target_next;

    logic [5:0]  opcode;
    logic [5:0]  funct;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [15:0] imm;
    logic [rde_pkg::XLEN-1:0] simm;
    logic [rde_pkg::XLEN-1:0] zimm;
    logic        wr;
    logic        bad;

    assign opcode = instruction[31:26];
    assign rt     = instruction[20:16];
    assign rd     = instruction[15:11];
    assign funct  = instruction[5:0];
    assign imm    = instruction[15:0];
    assign simm   = {{16{imm[15]}}, imm};
    assign zimm   = {16'h0000, imm};

    always_comb
    begin
        ctrl_next   = '0;
        op_a_next   = rs_value;
        op_b_next   = rt_value;
        shamt_next  = instruction[10:6];
        target_next = pc_next + simm;
        wr          = 1'b0;
        bad         = 1'b0;
        ctrl_next.alu_op  = rde_pkg::ALU_ZERO;
        ctrl_next.br_kind = rde_pkg::BR_NONE;

        unique case (opcode)
            rde_pkg::OP_SPECIAL:
            begin
                ctrl_next.dest = rd;
                wr = 1'b1;
                unique case (funct)
                    rde_pkg::FN_SLL:  ctrl_next.alu_op = rde_pkg::ALU_SLL;
                    rde_pkg::FN_SRL:  ctrl_next.alu_op = rde_pkg::ALU_SRL;
                    rde_pkg::FN_SRA:  ctrl_next.alu_op = rde_pkg::ALU_SRA;
                    rde_pkg::FN_SLLV:
                    begin
                        ctrl_next.alu_op = rde_pkg::ALU_SLL;
                        shamt_next = rs_value[4:0];
                    end
                    rde_pkg::FN_SRLV:
                    begin
                        ctrl_next.alu_op = rde_pkg::ALU_SRL;
                        shamt_next = rs_value[4:0];
                    end
                    rde_pkg::FN_SRAV:
                    begin
                        ctrl_next.alu_op = rde_pkg::ALU_SRA;
                        shamt_next = rs_value[4:0];
                    end
                    rde_pkg::FN_ADD, rde_pkg::FN_ADDU:
                        ctrl_next.alu_op = rde_pkg::ALU_ADD;
                    rde_pkg::FN_SUB, rde_pkg::FN_SUBU:
                        ctrl_next.alu_op = rde_pkg::ALU_SUB;
                    rde_pkg::FN_AND:  ctrl_next.alu_op = rde_pkg::ALU_AND;
                    rde_pkg::FN_OR:   ctrl_next.alu_op = rde_pkg::ALU_OR;
                    rde_pkg::FN_XOR:  ctrl_next.alu_op = rde_pkg::ALU_XOR;
                    rde_pkg::FN_NOR:  ctrl_next.alu_op = rde_pkg::ALU_NOR;
                    rde_pkg::FN_SLT:  ctrl_next.alu_op = rde_pkg::ALU_SLT;
                    rde_pkg::FN_SLTU: ctrl_next.alu_op = rde_pkg::ALU_SLTU;
                    default:          bad = 1'b1;
                endcase
            end
            rde_pkg::OP_REGIMM:
            begin
                if (rt == rde_pkg::RT_BLTZ)
                    ctrl_next.br_kind = rde_pkg::BR_LTZ;
                else
                    bad = 1'b1;
            end
            rde_pkg::OP_J:
            begin
                ctrl_next.br_kind = rde_pkg::BR_JUMP;
                target_next = (pc_next & rde_pkg::JUMP_REGION_MASK)
                            | {6'b0, instruction[25:0]};
            end
            rde_pkg::OP_JAL:
            begin
                ctrl_next.br_kind = rde_pkg::BR_JUMP;
                target_next = (pc_next & rde_pkg::JUMP_REGION_MASK)
                            | {6'b0, instruction[25:0]};
                ctrl_next.alu_op = rde_pkg::ALU_PASS_B;
                op_b_next = pc_next;
                ctrl_next.dest = rde_pkg::LINK_REG;
                wr = 1'b1;
            end
            rde_pkg::OP_BEQ:  ctrl_next.br_kind = rde_pkg::BR_EQ;
            rde_pkg::OP_BNE:  ctrl_next.br_kind = rde_pkg::BR_NE;
            rde_pkg::OP_BLEZ: ctrl_next.br_kind = rde_pkg::BR_LEZ;
            rde_pkg::OP_BGTZ: ctrl_next.br_kind = rde_pkg::BR_GTZ;
            rde_pkg::OP_ADDI, rde_pkg::OP_ADDIU:
            begin
                ctrl_next.dest = rt; wr = 1'b1;
                ctrl_next.alu_op = rde_pkg::ALU_ADD; op_b_next = simm;
            end
            rde_pkg::OP_SLTI:
            begin
                ctrl_next.dest = rt; wr = 1'b1;
                ctrl_next.alu_op = rde_pkg::ALU_SLT; op_b_next = simm;
            end
            rde_pkg::OP_SLTIU:
            begin
                ctrl_next.dest = rt; wr = 1'b1;
                ctrl_next.alu_op = rde_pkg::ALU_SLTU; op_b_next = simm;
            end
            rde_pkg::OP_ANDI:
            begin
                ctrl_next.dest = rt; wr = 1'b1;
                ctrl_next.alu_op = rde_pkg::ALU_AND; op_b_next = zimm;
            end
            rde_pkg::OP_ORI:
            begin
                ctrl_next.dest = rt; wr = 1'b1;
                ctrl_next.alu_op = rde_pkg::ALU_OR; op_b_next = zimm;
            end
            rde_pkg::OP_XORI:
            begin
                ctrl_next.dest = rt; wr = 1'b1;
                ctrl_next.alu_op = rde_pkg::ALU_XOR; op_b_next = zimm;
            end
            rde_pkg::OP_LUI:
            begin
                ctrl_next.dest = rt; wr = 1'b1;
                ctrl_next.alu_op = rde_pkg::ALU_PASS_B;
                op_b_next = {imm, 16'h0000};
            end
            rde_pkg::OP_LW:
            begin
                ctrl_next.dest = rt; wr = 1'b1;
                ctrl_next.mem_load = 1'b1;
                ctrl_next.alu_op = rde_pkg::ALU_ADD; op_b_next = simm;
            end
            default: bad = 1'b1;
        endcase

        // illegal word: everything but the flag reads zero
        if (bad)
        begin
            ctrl_next = '0;
            ctrl_next.alu_op  = rde_pkg::ALU_ZERO;
            ctrl_next.br_kind = rde_pkg::BR_NONE;
            ctrl_next.illegal = 1'b1;
            wr = 1'b0;
        end
        ctrl_next.reg_write = wr && (ctrl_next.dest != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (load && valid_in)
        begin
            ctrl_reg   <= ctrl_next;
            op_a_reg   <= op_a_next;
            op_b_reg   <= op_b_next;
            shamt_reg  <= shamt_next;
            target_reg <= target_next;
        end
    end

    assign valid  = valid_reg;
    assign ctrl   = ctrl_reg;
    assign op_a   = op_a_reg;
    assign op_b   = op_b_reg;
    assign shamt  = shamt_reg;
    assign target = target_reg;

endmodule

// ----- hw/rtl/rde_execute.sv -----
// Stage 2: ALU (add/sub, shifter, logic, compares) and branch condition.
// Depends on rde_pkg; fed by rde_decode.
module rde_execute (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic                     valid_in,
    input  rde_pkg::ctrl_t           ctrl_in,
    input  logic [rde_pkg::XLEN-1:0] op_a,
    input  logic [rde_pkg::XLEN-1:0] op_b,
    input  logic [4:0]               shamt,
    input  logic [rde_pkg::XLEN-1:0] target_in,
    output logic                     valid,
    output rde_pkg::ctrl_t           ctrl,
    output logic [rde_pkg::XLEN-1:0] result,
    output logic                     taken,
    output logic [rde_pkg::XLEN-1:0] target
);

    logic                     valid_reg;
    rde_pkg::ctrl_t           ctrl_reg;
    logic [rde_pkg::XLEN-1:0] result_reg, result_next;
    logic                     taken_reg, taken_next;
    logic [rde_pkg::XLEN-1:0] target_reg;

    logic a_neg;
    logic a_zero;

    assign a_neg  = op_a[rde_pkg::XLEN-1];
    assign a_zero = (op_a == '0);

    always_comb
    begin
        unique case (ctrl_in.alu_op)
            rde_pkg::ALU_SLL:    result_next = op_b << shamt;
            rde_pkg::ALU_SRL:    result_next = op_b >> shamt;
            rde_pkg::ALU_SRA:    result_next = $unsigned($signed(op_b) >>> shamt);
            rde_pkg::ALU_ADD:    result_next = op_a + op_b;
            rde_pkg::ALU_SUB:    result_next = op_a - op_b;
            rde_pkg::ALU_AND:    result_next = op_a & op_b;
            rde_pkg::ALU_OR:     result_next = op_a | op_b;
            rde_pkg::ALU_XOR:    result_next = op_a ^ op_b;
            rde_pkg::ALU_NOR:    result_next = ~(op_a | op_b);
            rde_pkg::ALU_SLT:
                result_next = {31'b0, ($signed(op_a) < $signed(op_b))};
            rde_pkg::ALU_SLTU:   result_next = {31'b0, (op_a < op_b)};
            rde_pkg::ALU_PASS_B: result_next = op_b;
            default:             result_next = '0;
        endcase
    end

    always_comb
    begin
        unique case (ctrl_in.br_kind)
            rde_pkg::BR_EQ:   taken_next = (op_a == op_b);
            rde_pkg::BR_NE:   taken_next = (op_a != op_b);
            rde_pkg::BR_LTZ:  taken_next = a_neg;
            rde_pkg::BR_LEZ:  taken_next = a_neg || a_zero;
            rde_pkg::BR_GTZ:  taken_next = !a_neg && !a_zero;
            rde_pkg::BR_JUMP: taken_next = 1'b1;
            default:          taken_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (load && valid_in)
        begin
            ctrl_reg   <= ctrl_in;
            result_reg <= result_next;
            taken_reg  <= taken_next;
            target_reg <= target_in;
        end
    end

    assign valid  = valid_reg;
    assign ctrl   = ctrl_reg;
    assign result = result_reg;
    assign taken  = taken_reg;
    assign target = target_reg;

endmodule

// ----- hw/rtl/risc_decode_execute_unit_core.sv -----
// Top level of the integer decode/execute pipeline: stage control and output register.
// Depends on rde_pkg, rde_decode and rde_execute.
//
// Usage:
//   Input channel: instruction, rs_value, rt_value and pc_next with in_valid and
//   in_stall. A word is taken at a clock edge with in_valid high and in_stall low.
//   Output channel: result, dest_reg, reg_write, mem_load, branch_taken, target_pc
//   and illegal with out_valid and out_stall; a word leaves when out_valid is high
//   and out_stall low. Each input word gives exactly one output word, in order.
//   Registers: decode, execute and output, in that order.
//   Throughput: one word per cycle while the receiver does not stall.
//   On stall the output word holds; earlier stages keep filling their empty slots
//   and in_stall rises only once all three stages hold a word.
//   Reset (rst_n low, asynchronous) empties the pipe; nothing is lost across a
//   stall since every stage only moves when the next one can take its word.
module risc_decode_execute_unit_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rde_pkg::XLEN-1:0]      instruction,
    input  logic [rde_pkg::XLEN-1:0]      rs_value,
    input  logic [rde_pkg::XLEN-1:0]      rt_value,
    input  logic [rde_pkg::XLEN-1:0]      pc_next,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rde_pkg::XLEN-1:0]      result,
    output logic [rde_pkg::REG_ADDR_W-1:0] dest_reg,
    output logic                          reg_write,
    output logic                          mem_load,
    output logic                          branch_taken,
    output logic [rde_pkg::XLEN-1:0]      target_pc,
    output logic                          illegal
);

    logic adv1, adv2, adv3;

    logic                     s1_valid;
    rde_pkg::ctrl_t           s1_ctrl;
    logic [rde_pkg::XLEN-1:0] s1_op_a, s1_op_b, s1_target;
    logic [4:0]               s1_shamt;

    logic                     s2_valid;
    rde_pkg::ctrl_t           s2_ctrl;
    logic [rde_pkg::XLEN-1:0] s2_result, s2_target;
    logic                     s2_taken;

    logic                      valid_reg;
    logic [rde_pkg::XLEN-1:0]  result_reg;
    logic [rde_pkg::REG_ADDR_W-1:0] dest_reg_reg;
    logic                      reg_write_reg;
    logic                      mem_load_reg;
    logic                      taken_reg;
    logic [rde_pkg::XLEN-1:0]  target_reg, target_next;
    logic                      illegal_reg;

    // a stage moves when it is empty or its word moves on
    assign adv3 = !valid_reg || !out_stall;
    assign adv2 = !s2_valid || adv3;
    assign adv1 = !s1_valid || adv2;
    assign in_stall = !adv1;

    rde_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (adv1),
        .valid_in    (in_valid),
        .instruction (instruction),
        .rs_value    (rs_value),
        .rt_value    (rt_value),
        .pc_next     (pc_next),
        .valid       (s1_valid),
        .ctrl        (s1_ctrl),
        .op_a        (s1_op_a),
        .op_b        (s1_op_b),
        .shamt       (s1_shamt),
        .target      (s1_target)
    );

    rde_execute u_execute (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv2),
        .valid_in  (s1_valid),
        .ctrl_in   (s1_ctrl),
        .op_a      (s1_op_a),
        .op_b      (s1_op_b),
        .shamt     (s1_shamt),
        .target_in (s1_target),
        .valid     (s2_valid),
        .ctrl      (s2_ctrl),
        .result    (s2_result),
        .taken     (s2_taken),
        .target    (s2_target)
    );

    assign target_next = s2_taken ? s2_target : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv3)
            valid_reg <= s2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_valid)
        begin
            result_reg    <= s2_result;
            dest_reg_reg  <= s2_ctrl.dest;
            reg_write_reg <= s2_ctrl.reg_write;
            mem_load_reg  <= s2_ctrl.mem_load;
            taken_reg     <= s2_taken;
            target_reg    <= target_next;
            illegal_reg   <= s2_ctrl.illegal;
        end
    end

    assign out_valid    = valid_reg;
    assign result       = result_reg;
    assign dest_reg     = dest_reg_reg;
    assign reg_write    = reg_write_reg;
    assign mem_load     = mem_load_reg;
    assign branch_taken = taken_reg;
    assign target_pc    = target_reg;
    assign illegal      = illegal_reg;

    // illegal word carries nothing else
    a_illegal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && illegal |-> result == '0 && dest_reg == '0 && !reg_write
            && !mem_load && !branch_taken && target_pc == '0)
        else $error("illegal word with live fields");

    a_no_write_r0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reg_write |-> dest_reg != '0)
        else $error("write to register zero");

    a_target_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !branch_taken |-> target_pc == '0)
        else $error("target set without a taken branch");

    a_load_no_branch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mem_load |-> !branch_taken && !illegal)
        else $error("load flagged with branch or illegal");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_stall && out_valid && s1_valid && s2_valid)
        else $error("input stalled with room in the pipe");

endmodule
